[sv/uabd_pkg.sv]
// ----------------------------------------------------------------------------
// uabd_pkg
// Shared types and constants of the angle batch deframer: configuration
// bundle, classified byte passed from front to back, and result record.
// ----------------------------------------------------------------------------
package uabd_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_MAGIC   = 2'd1;
  localparam logic [1:0] REG_NODE    = 2'd2;

  // Reset values of the registers
  localparam logic [30:0] TIMEOUT_RESET = 31'd50;
  localparam logic [7:0]  MAGIC_RESET   = 8'hC6;
  localparam logic [2:0]  NODE_RESET    = 3'd0;

  // Tag byte that follows the sequence byte in the bus payload
  localparam logic [7:0] PAYLOAD_TAG = 8'h01;

  // Angle slots the bus payload has room for
  localparam int MAX_MOTORS = 6;

  typedef struct packed {
    logic [30:0] timeout_ms;
    logic [7:0]  magic_value;
    logic [2:0]  node_index;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       is_magic;
    logic       timed_out;
  } item_t;

  typedef struct packed {
    logic              accepted;
    logic              frame_done;
    logic [7:0]        batch_seq;
    logic [63:0]       bus_payload;
    logic signed [7:0] own_angle;
  } result_t;

endpackage

[sv/uart_angle_batch_deframer.sv]
// ----------------------------------------------------------------------------
// uart_angle_batch_deframer
// Magic-byte fixed-length frame parser for batches of motor angles.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive rx_byte/now_ms with push; a byte is taken on a
//   clock edge with push high and full low. Every byte gives one result.
//   Result queue side: while empty is low the oldest result sits on
//   accepted/frame_done/batch_seq/bus_payload/own_angle; pop takes it.
//   Path: a taken byte is classified and stored in the middle queue; the
//   frame tracker then builds its result into the result queue.
//   Throughput: one byte per cycle while the result queue is not full; the
//   frame position update in the back part is the loop that sets it.
//   Stall: when pop stays low the result queue fills, the back part holds,
//   the middle queue fills and full rises; nothing is dropped.
//   Reset (rst, synchronous): registers return to 50 ms timeout, magic
//   0xC6, node 0; frame position idle, last arrival time zero, queues empty.
//   Configuration: APB writes at 0x0 (timeout), 0x4 (magic), 0x8 (node);
//   write them only while no byte is in flight; pready is always high.
// ----------------------------------------------------------------------------
module uart_angle_batch_deframer #(
  parameter int MOTOR_COUNT = 6
) (
  input  logic              clk,
  input  logic              rst,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input queue
  input  logic              push,
  output logic              full,
  input  logic [7:0]        rx_byte,
  input  logic [31:0]       now_ms,
  // result queue
  output logic              empty,
  input  logic              pop,
  output logic              accepted,
  output logic              frame_done,
  output logic [7:0]        batch_seq,
  output logic [63:0]       bus_payload,
  output logic signed [7:0] own_angle
);
  import uabd_pkg::*;

  localparam int ITEM_W = $bits(item_t);
  localparam int RES_W  = $bits(result_t);

  cfg_t              cfg;
  logic              cfg_wr;
  item_t             front_item;
  logic              front_push;
  logic              mid_full;
  logic              mid_empty;
  logic              mid_pop;
  logic [ITEM_W-1:0] mid_rdata;
  item_t             back_item;
  logic              out_push;
  logic              out_full;
  result_t           back_res;
  logic [RES_W-1:0]  out_rdata;
  result_t           head;

  // Configuration registers: write on the access phase, ignore unused slots
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ms  <= TIMEOUT_RESET;
      cfg.magic_value <= MAGIC_RESET;
      cfg.node_index  <= NODE_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_TIMEOUT: cfg.timeout_ms  <= pwdata[30:0];
        REG_MAGIC:   cfg.magic_value <= pwdata[7:0];
        REG_NODE:    cfg.node_index  <= pwdata[2:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TIMEOUT: prdata = {1'b0, cfg.timeout_ms};
      REG_MAGIC:   prdata = {24'd0, cfg.magic_value};
      REG_NODE:    prdata = {29'd0, cfg.node_index};
      default:     prdata = '0;
    endcase
  end

  // Front: classify each byte (gap timeout, magic match)
  uabd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .full     (full),
    .rx_byte  (rx_byte),
    .now_ms   (now_ms),
    .mid_push (front_push),
    .mid_full (mid_full),
    .mid_item (front_item)
  );

  // Middle queue decouples front from the frame tracker
  uabd_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (2)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .full  (mid_full),
    .wdata (front_item),
    .pop   (mid_pop),
    .empty (mid_empty),
    .rdata (mid_rdata)
  );

  assign back_item = item_t'(mid_rdata);

  // Back: track the frame and build results
  uabd_back #(
    .MOTOR_COUNT (MOTOR_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .node_index (cfg.node_index),
    .mid_empty  (mid_empty),
    .mid_pop    (mid_pop),
    .mid_item   (back_item),
    .out_push   (out_push),
    .out_full   (out_full),
    .res        (back_res)
  );

  // Result queue holds finished results while the receiver stalls
  uabd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .full  (out_full),
    .wdata (back_res),
    .pop   (pop),
    .empty (empty),
    .rdata (out_rdata)
  );

  assign head        = result_t'(out_rdata);
  assign accepted    = head.accepted;
  assign frame_done  = head.frame_done;
  assign batch_seq   = head.batch_seq;
  assign bus_payload = head.bus_payload;
  assign own_angle   = head.own_angle;

endmodule

[sv/uabd_fifo.sv]
// ----------------------------------------------------------------------------
// uabd_fifo
// Small flop-based queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module uabd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + CNT_W'(1))
    else $error("queue count did not advance on push");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> count == $past(count) - CNT_W'(1))
    else $error("queue count did not drop on pop");

endmodule

[sv/uabd_front.sv]
// ----------------------------------------------------------------------------
// uabd_front
// Input side: take a byte, test the inter-byte gap and the magic value,
// and hand the classified byte to the middle queue.
// ----------------------------------------------------------------------------
module uabd_front (
  input  logic            clk,
  input  logic            rst,
  input  uabd_pkg::cfg_t  cfg,
  input  logic            push,
  output logic            full,
  input  logic [7:0]      rx_byte,
  input  logic [31:0]     now_ms,
  output logic            mid_push,
  input  logic            mid_full,
  output uabd_pkg::item_t mid_item
);
  import uabd_pkg::*;

  logic [31:0] last_byte_time;
  logic [31:0] gap;

  assign full     = mid_full;
  assign mid_push = push;

  // Negative gap (wrapped backwards) never times out
  assign gap = now_ms - last_byte_time;

  always_comb begin
    mid_item.rx_byte   = rx_byte;
    mid_item.is_magic  = (rx_byte == cfg.magic_value);
    mid_item.timed_out = ~gap[31] & (gap[30:0] > cfg.timeout_ms);
  end

  // Record the arrival time of every accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      last_byte_time <= '0;
    end else if (push && !mid_full) begin
      last_byte_time <= now_ms;
    end
  end

endmodule

[sv/uabd_back.sv]
// ----------------------------------------------------------------------------
// uabd_back
// Frame tracker: advance the frame position, collect the frame bytes and
// build the result record for each classified byte.
// ----------------------------------------------------------------------------
module uabd_back #(
  parameter int MOTOR_COUNT = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [2:0]        node_index,
  input  logic              mid_empty,
  output logic              mid_pop,
  input  uabd_pkg::item_t   mid_item,
  output logic              out_push,
  input  logic              out_full,
  output uabd_pkg::result_t res
);
  import uabd_pkg::*;

  localparam int SLOTS = MOTOR_COUNT + 1;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int POS_W = $clog2(MOTOR_COUNT + 2);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(MOTOR_COUNT + 1);
  localparam logic [3:0] MC4 = 4'(MOTOR_COUNT);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [POS_W-1:0] pos_eff;
  logic [7:0]       frame_bytes [SLOTS];
  logic [7:0]       view [SLOTS];
  logic [7:0]       pl_bytes [MAX_MOTORS];
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] own_sel;
  logic             own_ok;
  logic             wr_en;
  logic             done;
  logic             advance;
  logic [63:0]      payload;

  assign advance  = ~mid_empty & ~out_full;
  assign mid_pop  = advance;
  assign out_push = advance;

  // A timed-out partial frame is dropped before the byte is looked at
  assign pos_eff = mid_item.timed_out ? '0 : pos;
  assign wr_en   = ~mid_item.is_magic & (pos_eff != '0);
  assign wr_idx  = IDX_W'(pos_eff - POS_W'(1));
  assign done    = wr_en & (pos_eff == LAST_POS);

  always_comb begin
    if (mid_item.is_magic) begin
      pos_next = POS_W'(1);
    end else if (pos_eff == '0 || done) begin
      pos_next = '0;
    end else begin
      pos_next = pos_eff + POS_W'(1);
    end
  end

  // Frame bytes with the current byte forwarded into its slot
  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      view[k] = (wr_en && wr_idx == IDX_W'(k)) ? mid_item.rx_byte : frame_bytes[k];
    end
  end

  for (genvar g = 0; g < MAX_MOTORS; g++) begin : g_slot
    if (g < MOTOR_COUNT) begin : g_used
      assign pl_bytes[g] = view[g+1];
    end else begin : g_unused
      assign pl_bytes[g] = '0;
    end
  end

  always_comb begin
    payload       = '0;
    payload[7:0]  = view[0];
    payload[15:8] = PAYLOAD_TAG;
    for (int i = 0; i < MAX_MOTORS; i++) begin
      payload[8*(i+2) +: 8] = pl_bytes[i];
    end
  end

  assign own_ok  = ({1'b0, node_index} < MC4);
  assign own_sel = IDX_W'({1'b0, node_index} + 4'd1);

  always_comb begin
    res.accepted    = mid_item.is_magic | wr_en;
    res.frame_done  = done;
    res.batch_seq   = done ? view[0] : '0;
    res.bus_payload = done ? payload : '0;
    res.own_angle   = (done && own_ok) ? view[own_sel] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (advance) begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && wr_en) begin
      frame_bytes[wr_idx] <= mid_item.rx_byte;
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (rst) pos <= LAST_POS)
    else $error("frame position out of range");
  a_done_accepted: assert property (@(posedge clk) disable iff (rst)
    (out_push && res.frame_done) |-> res.accepted)
    else $error("completed frame on a rejected byte");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_push && res.frame_done) |=> pos == '0)
    else $error("frame position not idle after completion");

endmodule
